/* rtl/dtsp_pkg.sv */
package dtsp_pkg;

	localparam int MAX_DEPTH       = 64;
	localparam int MAX_BLOCK_BYTES = 67108864;

	localparam int WORD_W      = 32;
	localparam int OFF_W       = 27;
	localparam int OUT_OFF_W   = 28;
	localparam int OUT_DEPTH_W = 7;
	localparam int DEPTH_W     = $clog2(MAX_DEPTH + 1);

	// queue between front and back, power of two
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// structure block tokens
	localparam logic [WORD_W-1:0] TOK_BEGIN   = 32'h1;
	localparam logic [WORD_W-1:0] TOK_ENDNODE = 32'h2;
	localparam logic [WORD_W-1:0] TOK_PROP    = 32'h3;
	localparam logic [WORD_W-1:0] TOK_NOP     = 32'h4;
	localparam logic [WORD_W-1:0] TOK_END     = 32'h9;

	// result kinds
	localparam logic [2:0] KIND_BEGIN = 3'd0;
	localparam logic [2:0] KIND_ENDN  = 3'd1;
	localparam logic [2:0] KIND_PROP  = 3'd2;
	localparam logic [2:0] KIND_DATA  = 3'd3;
	localparam logic [2:0] KIND_END   = 3'd4;
	localparam logic [2:0] KIND_ERROR = 3'd5;

	// error codes
	localparam logic [3:0] ERR_NONE       = 4'd0;
	localparam logic [3:0] ERR_UNKNOWN    = 4'd1;
	localparam logic [3:0] ERR_FIRST      = 4'd2;
	localparam logic [3:0] ERR_NAME       = 4'd3;
	localparam logic [3:0] ERR_PROP_HDR   = 4'd4;
	localparam logic [3:0] ERR_PROP_DATA  = 4'd5;
	localparam logic [3:0] ERR_UNOPENED   = 4'd6;
	localparam logic [3:0] ERR_NO_END     = 4'd7;
	localparam logic [3:0] ERR_DEPTH_OVER = 4'd8;

	// configuration register indexes
	localparam logic CFG_BLOCK_SIZE  = 1'b0;
	localparam logic CFG_BLOCK_START = 1'b1;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              restart;
	} item_t;

	typedef struct packed {
		logic [2:0]             kind;
		logic [OUT_OFF_W-1:0]   token_offset;
		logic [OUT_DEPTH_W-1:0] depth;
		logic [OFF_W-1:0]       prop_length;
		logic [WORD_W-1:0]      name_offset;
		logic [WORD_W-1:0]      data_word;
		logic [2:0]             valid_bytes;
		logic [3:0]             error_code;
		logic                   final_in_run;
	} result_t;

	// one queue entry: the results of one word
	typedef struct packed {
		result_t              first;
		logic                 two;
		logic [OUT_OFF_W-1:0] second_off;
	} qent_t;

	typedef struct packed {
		logic  push;
		qent_t ent;
	} qwr_t;

	typedef struct packed {
		logic  empty;
		qent_t ent;
	} qrd_t;

endpackage

/* rtl/dtsp_front.sv */
module dtsp_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  dtsp_pkg::item_t         item,
	input  logic                    cfg_we,
	input  logic                    cfg_index,
	input  logic [26:0]             cfg_data,
	input  logic                    q_full,
	output dtsp_pkg::qwr_t          qwr
);
	import dtsp_pkg::*;

	localparam logic [2:0] PH_TOKEN = 3'd0;
	localparam logic [2:0] PH_NAME  = 3'd1;
	localparam logic [2:0] PH_PLEN  = 3'd2;
	localparam logic [2:0] PH_PNAME = 3'd3;
	localparam logic [2:0] PH_DATA  = 3'd4;

	localparam logic [OFF_W-1:0] MAX_BS = OFF_W'(MAX_BLOCK_BYTES);

	logic [OFF_W-1:0]   bs_q, start_q;
	logic [2:0]         phase_q, phase_e, phase_n;
	logic [OFF_W-1:0]   off_q, off_e, off_n;
	logic [DEPTH_W-1:0] depth_q, depth_e, depth_n;
	logic               root_q, root_e, root_n;
	logic [OFF_W-1:0]   left_q, left_e, left_n;
	logic [OFF_W-1:0]   plen_q, plen_e, plen_n;
	logic [OFF_W-1:0]   tstart_q, tstart_e, tstart_n;
	logic               stop_q, stop_e, stop_n;

	logic               accept;
	logic [OFF_W-1:0]   rem, sat, vlen, ev_off;
	logic [WORD_W-1:0]  plim;
	logic               last, have1, nul;
	logic [WORD_W-1:0]  w;
	logic [2:0]         f_kind, f_vb;
	logic [3:0]         f_err;
	logic [OFF_W-1:0]   f_plen;
	logic [WORD_W-1:0]  f_name, f_data;
	qent_t              ent;

	assign item_stall = q_full;
	assign accept     = item_valid && !q_full;
	assign w          = item.word;

	// saturate and align block size at write time
	assign sat = (cfg_data > MAX_BS) ? MAX_BS : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q    <= '0;
			start_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_BLOCK_SIZE) begin
				bs_q <= sat & ~OFF_W'(3);
			end else begin
				start_q <= cfg_data;
			end
		end
	end

	// restart clears the context before this word is looked at
	always_comb begin
		phase_e  = item.restart ? PH_TOKEN : phase_q;
		off_e    = item.restart ? '0 : off_q;
		depth_e  = item.restart ? '0 : depth_q;
		root_e   = item.restart ? 1'b0 : root_q;
		left_e   = item.restart ? '0 : left_q;
		plen_e   = item.restart ? '0 : plen_q;
		tstart_e = item.restart ? '0 : tstart_q;
		stop_e   = item.restart ? 1'b0 : stop_q;
	end

	assign rem  = bs_q - off_e;
	assign last = (rem == OFF_W'(4));
	assign nul  = (w[31:24] == 8'd0) || (w[23:16] == 8'd0) || (w[15:8] == 8'd0)
		|| (w[7:0] == 8'd0);
	assign vlen = (left_e > OFF_W'(4)) ? OFF_W'(4) : left_e;
	// room for the value after the 12-byte header, at full word width
	assign plim = {{(WORD_W-OFF_W){1'b0}}, bs_q} - {{(WORD_W-OFF_W){1'b0}}, tstart_e}
		- WORD_W'(12);

	always_comb begin
		phase_n  = phase_e;
		off_n    = off_e;
		depth_n  = depth_e;
		root_n   = root_e;
		left_n   = left_e;
		plen_n   = plen_e;
		tstart_n = tstart_e;
		stop_n   = stop_e;
		have1    = 1'b0;
		f_kind   = KIND_ERROR;
		f_err    = ERR_NONE;
		f_plen   = '0;
		f_name   = '0;
		f_data   = '0;
		f_vb     = '0;
		ev_off   = off_e;
		ent      = '0;
		if (!stop_e) begin
			if (off_e >= bs_q) begin
				have1  = 1'b1;
				f_err  = ERR_NO_END;
				stop_n = 1'b1;
			end else begin
				case (phase_e)
					PH_NAME: begin
						if (nul) begin
							phase_n = PH_TOKEN;
						end else if (last) begin
							have1  = 1'b1;
							f_err  = ERR_NAME;
							stop_n = 1'b1;
						end
					end
					PH_PLEN: begin
						if (w > plim) begin
							have1  = 1'b1;
							f_err  = ERR_PROP_DATA;
							stop_n = 1'b1;
						end else begin
							plen_n  = w[OFF_W-1:0];
							phase_n = PH_PNAME;
						end
					end
					PH_PNAME: begin
						have1   = 1'b1;
						f_kind  = KIND_PROP;
						f_plen  = plen_e;
						f_name  = w;
						ev_off  = tstart_e;
						left_n  = plen_e;
						phase_n = (plen_e != '0) ? PH_DATA : PH_TOKEN;
					end
					PH_DATA: begin
						have1  = 1'b1;
						f_kind = KIND_DATA;
						f_plen = plen_e;
						f_data = w;
						f_vb   = vlen[2:0];
						left_n = left_e - vlen;
						if (left_e == vlen) begin
							phase_n = PH_TOKEN;
						end
					end
					default: begin
						phase_n = PH_TOKEN;
						if (!root_e && w != TOK_NOP && w != TOK_BEGIN) begin
							have1  = 1'b1;
							f_err  = ERR_FIRST;
							stop_n = 1'b1;
						end else if (w == TOK_NOP) begin
							// skip
						end else if (w == TOK_BEGIN) begin
							if (depth_e >= DEPTH_W'(MAX_DEPTH)) begin
								have1  = 1'b1;
								f_err  = ERR_DEPTH_OVER;
								stop_n = 1'b1;
							end else if (last) begin
								have1  = 1'b1;
								f_err  = ERR_NAME;
								stop_n = 1'b1;
							end else begin
								have1   = 1'b1;
								f_kind  = KIND_BEGIN;
								root_n  = 1'b1;
								depth_n = depth_e + DEPTH_W'(1);
								phase_n = PH_NAME;
							end
						end else if (w == TOK_ENDNODE) begin
							have1 = 1'b1;
							if (depth_e == '0) begin
								f_err  = ERR_UNOPENED;
								stop_n = 1'b1;
							end else begin
								f_kind  = KIND_ENDN;
								depth_n = depth_e - DEPTH_W'(1);
							end
						end else if (w == TOK_PROP) begin
							if (rem < OFF_W'(12)) begin
								have1  = 1'b1;
								f_err  = ERR_PROP_HDR;
								stop_n = 1'b1;
							end else begin
								tstart_n = off_e;
								phase_n  = PH_PLEN;
							end
						end else if (w == TOK_END) begin
							have1  = 1'b1;
							f_kind = KIND_END;
							stop_n = 1'b1;
						end else begin
							have1  = 1'b1;
							f_err  = ERR_UNKNOWN;
							stop_n = 1'b1;
						end
					end
				endcase
				off_n = off_e + OFF_W'(4);
				// last word consumed and no end token seen
				if (!stop_n && last) begin
					if (have1) begin
						ent.two = 1'b1;
					end else begin
						have1  = 1'b1;
						f_kind = KIND_ERROR;
						f_err  = ERR_NO_END;
						ev_off = off_e;
					end
					stop_n = 1'b1;
				end
			end
		end
		ent.first.kind         = f_kind;
		ent.first.token_offset = {1'b0, start_q} + {1'b0, ev_off};
		ent.first.depth        = OUT_DEPTH_W'(depth_n);
		ent.first.prop_length  = f_plen;
		ent.first.name_offset  = f_name;
		ent.first.data_word    = f_data;
		ent.first.valid_bytes  = f_vb;
		ent.first.error_code   = f_err;
		ent.first.final_in_run = !ent.two;
		ent.second_off         = {1'b0, start_q} + {1'b0, off_e};
	end

	assign qwr.push = accept && have1;
	assign qwr.ent  = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TOKEN;
			off_q    <= '0;
			depth_q  <= '0;
			root_q   <= 1'b0;
			left_q   <= '0;
			plen_q   <= '0;
			tstart_q <= '0;
			stop_q   <= 1'b1;
		end else if (accept) begin
			phase_q  <= phase_n;
			off_q    <= off_n;
			depth_q  <= depth_n;
			root_q   <= root_n;
			left_q   <= left_n;
			plen_q   <= plen_n;
			tstart_q <= tstart_n;
			stop_q   <= stop_n;
		end
	end

endmodule

/* rtl/dtsp_queue.sv */
module dtsp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  dtsp_pkg::qwr_t qwr,
	output logic           full,
	input  logic           pop,
	output dtsp_pkg::qrd_t qrd
);
	import dtsp_pkg::*;

	qent_t               mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                do_push, do_pop;

	assign full      = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign qrd.empty = (count_q == '0);
	assign qrd.ent   = mem_q[rd_ptr_q];
	assign do_push   = qwr.push && !full;
	assign do_pop    = pop && !qrd.empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= qwr.ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QUEUE_AW+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QUEUE_AW+1)'(1);
			end
		end
	end

endmodule

/* rtl/dtsp_back.sv */
module dtsp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  dtsp_pkg::qrd_t    qrd,
	output logic              pop,
	output logic              result_valid,
	input  logic              result_stall,
	output dtsp_pkg::result_t result
);
	import dtsp_pkg::*;

	logic    out_valid_q, sec_pend_q, adv;
	result_t out_q, sec_q, sec;

	assign adv = !out_valid_q || !result_stall;
	assign pop = adv && !sec_pend_q && !qrd.empty;

	// trailing missing-end error of a two-result word
	always_comb begin
		sec              = '0;
		sec.kind         = KIND_ERROR;
		sec.token_offset = qrd.ent.second_off;
		sec.depth        = qrd.ent.first.depth;
		sec.error_code   = ERR_NO_END;
		sec.final_in_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sec_pend_q  <= 1'b0;
		end else if (adv) begin
			if (sec_pend_q) begin
				out_valid_q <= 1'b1;
				sec_pend_q  <= 1'b0;
			end else begin
				out_valid_q <= !qrd.empty;
				sec_pend_q  <= !qrd.empty && qrd.ent.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (sec_pend_q) begin
				out_q <= sec_q;
			end else begin
				out_q <= qrd.ent.first;
				sec_q <= sec;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

/* rtl/devicetree_token_stream_parser.sv */
// Channel   Direction  Handshake                 Payload
// item      in         item_valid / item_stall   dtsp_pkg::item_t   (word, restart)
// result    out        result_valid / result_stall dtsp_pkg::result_t
// config    in         cfg_we                    cfg_index, cfg_data
//
// One word is taken every cycle while the result queue has room; the front
// decides all results of a word in the cycle it is transferred.
// A word yields zero, one or two results. The result register drains one per
// cycle while result_stall is low, so a steady run of two-result words fills the
// queue and stalls words. Each result is queued, then registered for output.
// Reset clears parser context and queue; the parser starts stopped and waits
// for a word with restart set. Config registers reset to zero.
// item_stall rises only when the four-entry queue is full.
module devicetree_token_stream_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  dtsp_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output dtsp_pkg::result_t result,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [26:0]       cfg_data
);
	import dtsp_pkg::*;

	qwr_t qwr;
	qrd_t qrd;
	logic q_full;
	logic pop;

	// front: classify each word, track offset and depth, build results
	dtsp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_full     (q_full),
		.qwr        (qwr)
	);

	// hold per-word result groups so each side can stall on its own
	dtsp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.qwr    (qwr),
		.full   (q_full),
		.pop    (pop),
		.qrd    (qrd)
	);

	// back: split each group into single result transfers
	dtsp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.qrd          (qrd),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

/* sim/devicetree_token_stream_parser_tb.sv */
`timescale 1ns / 100ps

module devicetree_token_stream_parser_tb;
	import dtsp_pkg::*;

	localparam int CLK_PERIOD     = 12;
	localparam int TIMEOUT_CYCLES = 600000;
	// words to send in all before the random blocks stop
	localparam int WORD_TARGET    = 650;
	// let in-flight words settle once nothing is expected: the queue and the result register
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_LIMIT    = 5000;
	localparam logic [26:0] SIZE_CAP = 27'(MAX_BLOCK_BYTES);

	// where the parser sits inside the structure block
	typedef enum logic [2:0] {
		SEEK_TOKEN,
		SKIP_NAME,
		GET_LENGTH,
		GET_NAME_OFF,
		TAKE_DATA
	} walk_t;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	item_t       item;
	logic        result_valid;
	logic        result_stall;
	result_t     result;
	logic        cfg_we;
	logic        cfg_index;
	logic [26:0] cfg_data;

	devicetree_token_stream_parser u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Register copies and parser context of the predictor.
	logic [26:0] cur_size  = '0;
	logic [26:0] cur_start = '0;
	walk_t       walk      = SEEK_TOKEN;
	logic [26:0] pr_offset    = '0;
	logic [7:0]  pr_depth     = '0;
	logic        pr_root      = 1'b0;
	logic [26:0] pr_left      = '0;
	logic [26:0] pr_len       = '0;
	logic [26:0] pr_tok_start = '0;
	logic        pr_halted    = 1'b1;

	// Events of the word being predicted, then the store of events still owed by the block.
	result_t step_events[$];
	result_t pending_events[$];

	logic [31:0] tree_words[$];

	int unsigned words_sent     = 0;
	int unsigned parsed_words   = 0;
	int unsigned events_checked = 0;
	int unsigned cfg_phases     = 0;
	int unsigned mismatches     = 0;
	int unsigned sink_hold      = 0;
	bit          src_steady     = 1'b0;

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Hard stop for a hung handshake.
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("[FAIL] regression broken");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic void note_event(input logic [2:0] kind, input logic [26:0] off,
			input logic [26:0] plen, input logic [31:0] name_off, input logic [31:0] data,
			input logic [2:0] vbytes, input logic [3:0] err);
		result_t ev;
		ev.kind         = kind;
		ev.token_offset = {1'b0, cur_start} + {1'b0, off};
		ev.depth        = pr_depth[6:0];
		ev.prop_length  = plen;
		ev.name_offset  = name_off;
		ev.data_word    = data;
		ev.valid_bytes  = vbytes;
		ev.error_code   = err;
		ev.final_in_run = 1'b0;
		step_events.push_back(ev);
	endfunction

	// Any error halts the parser until the next restart.
	function automatic void note_error(input logic [26:0] off, input logic [3:0] err);
		pr_halted = 1'b1;
		note_event(KIND_ERROR, off, '0, '0, '0, '0, err);
	endfunction

	// Advance the parser context by one transferred word and queue the events it owes.
	task automatic parse_word_events(input logic [31:0] w, input logic rs);
		logic [26:0] lim;
		logic [26:0] off;
		logic [31:0] room;
		logic [26:0] take;
		step_events.delete();
		if (rs) begin
			walk         = SEEK_TOKEN;
			pr_offset    = '0;
			pr_depth     = '0;
			pr_root      = 1'b0;
			pr_left      = '0;
			pr_len       = '0;
			pr_tok_start = '0;
			pr_halted    = 1'b0;
		end
		if (pr_halted)
			return;
		parsed_words++;

		// block size saturates and drops its low two bits
		lim = (cur_size > SIZE_CAP) ? SIZE_CAP : cur_size;
		lim[1:0] = 2'b00;
		off = pr_offset;

		if (off >= lim || lim - off < 27'd4) begin
			// word sits at or past the block end: no room at all
			note_error(off, ERR_NO_END);
		end else begin
			case (walk)
			SKIP_NAME: begin
				if (w[31:24] == 8'h00 || w[23:16] == 8'h00 || w[15:8] == 8'h00 ||
						w[7:0] == 8'h00)
					walk = SEEK_TOKEN;
				else if (lim - off == 27'd4)
					note_error(off, ERR_NAME);
			end
			GET_LENGTH: begin
				// header already fits, so this cannot wrap
				room = 32'(lim) - 32'(pr_tok_start) - 32'd12;
				if (w > room) begin
					note_error(off, ERR_PROP_DATA);
				end else begin
					pr_len = w[26:0];
					walk   = GET_NAME_OFF;
				end
			end
			GET_NAME_OFF: begin
				note_event(KIND_PROP, pr_tok_start, pr_len, w, '0, '0, ERR_NONE);
				pr_left = pr_len;
				walk    = (pr_len != '0) ? TAKE_DATA : SEEK_TOKEN;
			end
			TAKE_DATA: begin
				take = (pr_left > 27'd4) ? 27'd4 : pr_left;
				note_event(KIND_DATA, off, pr_len, '0, w, take[2:0], ERR_NONE);
				pr_left = pr_left - take;
				if (pr_left == '0)
					walk = SEEK_TOKEN;
			end
			default: begin
				walk = SEEK_TOKEN;
				if (!pr_root && w != TOK_NOP && w != TOK_BEGIN) begin
					note_error(off, ERR_FIRST);
				end else if (w == TOK_BEGIN) begin
					if (pr_depth >= MAX_DEPTH) begin
						note_error(off, ERR_DEPTH_OVER);
					end else if (lim - off == 27'd4) begin
						// no room left for a name
						note_error(off, ERR_NAME);
					end else begin
						pr_root  = 1'b1;
						pr_depth = pr_depth + 8'd1;
						note_event(KIND_BEGIN, off, '0, '0, '0, '0, ERR_NONE);
						walk = SKIP_NAME;
					end
				end else if (w == TOK_ENDNODE) begin
					if (pr_depth == '0) begin
						note_error(off, ERR_UNOPENED);
					end else begin
						pr_depth = pr_depth - 8'd1;
						note_event(KIND_ENDN, off, '0, '0, '0, '0, ERR_NONE);
					end
				end else if (w == TOK_PROP) begin
					if (lim - off < 27'd12) begin
						note_error(off, ERR_PROP_HDR);
					end else begin
						pr_tok_start = off;
						walk         = GET_LENGTH;
					end
				end else if (w == TOK_END) begin
					note_event(KIND_END, off, '0, '0, '0, '0, ERR_NONE);
					pr_halted = 1'b1;
				end else if (w != TOK_NOP) begin
					note_error(off, ERR_UNKNOWN);
				end
			end
			endcase

			pr_offset = off + 27'd4;
			// last word consumed and still running: the block ran out without END
			if (!pr_halted && lim - off == 27'd4)
				note_error(off, ERR_NO_END);
		end

		if (step_events.size() != 0) begin
			step_events[step_events.size() - 1].final_in_run = 1'b1;
			foreach (step_events[i])
				pending_events.push_back(step_events[i]);
		end
	endtask

	// ------------------------------------------------------------------
	// Result side: random stall and checker
	// ------------------------------------------------------------------

	// Hold each stall decision for a random stretch: mostly short stalls and open
	// runs, now and then a long open run or a long stall.
	initial begin
		int unsigned roll;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (sink_hold == 0) begin
				roll = $urandom_range(0, 99);
				if (roll < 55) begin
					result_stall <= 1'b0;
					sink_hold = $urandom_range(1, 20);
				end else if (roll < 90) begin
					result_stall <= 1'b1;
					sink_hold = $urandom_range(1, 3);
				end else if (roll < 97) begin
					result_stall <= 1'b0;
					sink_hold = $urandom_range(30, 80);
				end else begin
					result_stall <= 1'b1;
					sink_hold = $urandom_range(10, 40);
				end
			end else begin
				sink_hold--;
			end
		end
	end

	task automatic flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t mismatch: %s", $time, msg);
	endtask

	task automatic compare_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			flag_mismatch($sformatf("%s got %0h want %0h", what, got, want));
	endtask

	// Check every result transfer against the oldest owed event.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_events.size() == 0) begin
				flag_mismatch($sformatf("result kind %0d with nothing owed", result.kind));
			end else begin
				want = pending_events.pop_front();
				events_checked++;
				compare_field("kind", 32'(result.kind), 32'(want.kind));
				compare_field("token_offset", 32'(result.token_offset),
					32'(want.token_offset));
				compare_field("depth", 32'(result.depth), 32'(want.depth));
				compare_field("prop_length", 32'(result.prop_length),
					32'(want.prop_length));
				compare_field("name_offset", result.name_offset, want.name_offset);
				compare_field("data_word", result.data_word, want.data_word);
				compare_field("valid_bytes", 32'(result.valid_bytes),
					32'(want.valid_bytes));
				compare_field("error_code", 32'(result.error_code), 32'(want.error_code));
				compare_field("final_in_run", 32'(result.final_in_run),
					32'(want.final_in_run));
			end
		end
	end

	// ------------------------------------------------------------------
	// Word side
	// ------------------------------------------------------------------

	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (src_steady)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Drive one word and hold it until the transfer. Valid stays high when the next
	// word follows with no gap, so it is never lowered and raised in one step.
	task automatic send_word(input logic [31:0] w, input logic rs);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= '{word: w, restart: rs};
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		words_sent++;
		parse_word_events(w, rs);
	endtask

	// Drop valid, wait for every owed event, then let in-flight words that owe
	// nothing settle before the registers change.
	task automatic drain_results();
		int unsigned waited;
		waited = 0;
		item_valid <= 1'b0;
		while (pending_events.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_events.size() != 0) begin
			flag_mismatch($sformatf("%0d expected results never came", pending_events.size()));
			pending_events.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both registers, size then start; call only when idle.
	task automatic write_config(input logic [26:0] size, input logic [26:0] base);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_BLOCK_SIZE;
		cfg_data  <= size;
		@(posedge clk);
		cur_size = size;
		cfg_index <= CFG_BLOCK_START;
		cfg_data  <= base;
		@(posedge clk);
		cur_start = base;
		cfg_we <= 1'b0;
		cfg_phases++;
	endtask

	// Name tail: random bytes with at least one NUL.
	function automatic logic [31:0] nul_word();
		logic [31:0] w;
		if ($urandom_range(0, 4) == 0)
			return 32'h0;
		w = $urandom;
		w[8 * $urandom_range(0, 3) +: 8] = 8'h00;
		return w;
	endfunction

	function automatic logic [31:0] noise_word();
		if ($urandom_range(0, 99) < 60)
			return 32'($urandom_range(0, 15));
		return $urandom;
	endfunction

	function automatic logic [26:0] pick_base();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 15)
			return '0;
		if (roll < 30)
			return 27'h7FFFFFF;
		return 27'($urandom);
	endfunction

	// Mostly the exact size with junk in the ignored low bits; some short, some long,
	// some anywhere in the register range.
	function automatic logic [26:0] pick_size(input int unsigned words);
		int unsigned roll;
		int unsigned bytes;
		bytes = words * 4;
		roll  = $urandom_range(0, 99);
		if (roll < 60)
			return 27'(bytes + $urandom_range(0, 3));
		if (roll < 80)
			return 27'($urandom_range(0, bytes));
		if (roll < 92)
			return 27'(bytes + $urandom_range(4, 64));
		return 27'($urandom);
	endfunction

	// Append one well-formed node: name, up to two properties, maybe children.
	task automatic grow_node(input int lvl);
		int unsigned len;
		tree_words.push_back(TOK_BEGIN);
		repeat ($urandom_range(0, 2))
			tree_words.push_back({8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
				8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))});
		tree_words.push_back(nul_word());
		repeat ($urandom_range(0, 2)) begin
			len = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 12) : $urandom_range(13, 40);
			tree_words.push_back(TOK_PROP);
			tree_words.push_back(len);
			tree_words.push_back($urandom);
			repeat ((len + 3) / 4)
				tree_words.push_back($urandom);
			if ($urandom_range(0, 9) == 0)
				tree_words.push_back(TOK_NOP);
		end
		if (lvl < 3)
			repeat ($urandom_range(0, 2))
				if (tree_words.size() < 48)
					grow_node(lvl + 1);
		tree_words.push_back(TOK_ENDNODE);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Parser comes out of reset halted with zero-size registers.
	task automatic test_halted_start();
		send_word(TOK_BEGIN, 1'b0);   // halted: drop it, no event
		send_word(TOK_BEGIN, 1'b1);   // size zero: block already over
		drain_results();
		write_config(27'd3, 27'd0);   // low bits ignored, still empty
		send_word(TOK_NOP, 1'b1);
		drain_results();
		write_config(27'd4, 27'd5);
		send_word(TOK_BEGIN, 1'b1);   // begin in the only word: no room for a name
		send_word(TOK_END, 1'b1);     // end event, no trailing error
	endtask

	// One pass over every token and event kind but end, in a huge block at the top base.
	task automatic test_walkthrough();
		drain_results();
		write_config(27'h7FFFFFF, 27'h7FFFFFF);
		send_word(TOK_NOP, 1'b1);
		send_word(TOK_BEGIN, 1'b0);
		send_word(32'h61620000, 1'b0);
		send_word(TOK_PROP, 1'b0);
		send_word(32'd5, 1'b0);
		send_word(32'hFFFFFFFF, 1'b0);
		send_word(32'hDEADBEEF, 1'b0);
		send_word(32'h01000000, 1'b0);  // one meaningful byte
		send_word(TOK_ENDNODE, 1'b0);   // back at depth zero
		send_word(TOK_BEGIN, 1'b0);     // a second root is accepted
		send_word(32'h00000000, 1'b0);
		send_word(TOK_ENDNODE, 1'b0);
		send_word(TOK_ENDNODE, 1'b0);   // nothing open
		send_word(TOK_ENDNODE, 1'b1);   // first real token is not a begin
		send_word(TOK_BEGIN, 1'b1);
		send_word(32'h41424300, 1'b0);
		send_word(32'hFFFFFFFF, 1'b0);  // unknown token
	endtask

	// Small blocks that end inside a name, a header, a length and after an event.
	task automatic test_block_edges();
		drain_results();
		write_config(27'd12, 27'h5A5A5A5);
		send_word(TOK_BEGIN, 1'b1);
		send_word(32'h11111111, 1'b0);
		send_word(32'h22222222, 1'b0);  // name hits the end with no NUL
		send_word(TOK_BEGIN, 1'b1);
		send_word(32'h0, 1'b0);
		send_word(TOK_ENDNODE, 1'b0);   // end node, then out of block
		send_word(TOK_BEGIN, 1'b1);
		send_word(32'h0, 1'b0);
		send_word(TOK_PROP, 1'b0);      // header would pass the end
		drain_results();
		write_config(27'd24, 27'h0000ABC);
		send_word(TOK_BEGIN, 1'b1);
		send_word(32'h0, 1'b0);
		send_word(TOK_PROP, 1'b0);
		send_word(32'd5, 1'b0);         // one byte too long for the block
	endtask

	// Nest to the depth limit, step back, refill and push one past it.
	task automatic test_deep_nesting();
		drain_results();
		write_config(SIZE_CAP, pick_base());
		send_word(TOK_BEGIN, 1'b1);
		send_word(nul_word(), 1'b0);
		repeat (MAX_DEPTH - 1) begin
			send_word(TOK_BEGIN, 1'b0);
			send_word(nul_word(), 1'b0);
		end
		send_word(TOK_ENDNODE, 1'b0);
		send_word(TOK_BEGIN, 1'b0);
		send_word(nul_word(), 1'b0);
		send_word(TOK_BEGIN, 1'b0);
	endtask

	// Mostly well-formed trees with random content, some corrupted or cut short,
	// the rest raw noise with random restarts.
	task automatic test_random_blocks();
		while (words_sent < WORD_TARGET) begin
			src_steady = ($urandom_range(0, 99) < 30);
			if ($urandom_range(0, 99) < 20) begin
				if ($urandom_range(0, 1) == 1) begin
					drain_results();
					write_config(27'($urandom_range(0, 96)), pick_base());
				end
				repeat ($urandom_range(4, 14))
					send_word(noise_word(), $urandom_range(0, 99) < 20);
			end else begin
				tree_words.delete();
				repeat ($urandom_range(0, 2))
					tree_words.push_back(TOK_NOP);
				grow_node(1);
				if ($urandom_range(0, 3) == 0)
					grow_node(1);
				if ($urandom_range(0, 9) != 0)
					tree_words.push_back(TOK_END);
				if ($urandom_range(0, 4) == 0)
					tree_words[$urandom_range(0, tree_words.size() - 1)] = noise_word();
				// keep the old registers now and then: the size then rarely fits
				if ($urandom_range(0, 99) < 75) begin
					drain_results();
					write_config(pick_size(tree_words.size()), pick_base());
				end
				foreach (tree_words[i])
					send_word(tree_words[i], i == 0);
			end
		end
		src_steady = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		cfg_we     = 1'b0;
		cfg_index  = CFG_BLOCK_SIZE;
		cfg_data   = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_halted_start();
		test_walkthrough();
		test_block_edges();
		test_deep_nesting();
		test_random_blocks();
		drain_results();

		$display("sent %0d words (%0d parsed) under %0d register settings, %0d results checked",
			words_sent, parsed_words, cfg_phases, events_checked);
		$display("trees, noise, truncation, nesting to %0d, with gaps and stalls on both sides",
			MAX_DEPTH);
		if (mismatches == 0 && pending_events.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/dtsp_pkg.sv
rtl/dtsp_front.sv
rtl/dtsp_queue.sv
rtl/dtsp_back.sv
rtl/devicetree_token_stream_parser.sv
sim/devicetree_token_stream_parser_tb.sv
